[rtl/dfpd_pkg.sv]
// Shared types, byte constants and register codes for the dual-framing deframer.
`timescale 1ns / 1ps
`default_nettype none
package dfpd_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 32;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_00   = 8'h00;
  localparam logic [7:0] BYTE_A5   = 8'hA5;
  localparam logic [7:0] BYTE_DLE  = 8'h10;
  localparam logic [7:0] BYTE_STX  = 8'h02;
  localparam logic [7:0] BYTE_ETX  = 8'h03;
  localparam logic [7:0] SEED_SHRT = 8'h12;
  localparam logic [7:0] BYTE_DIR  = 8'h50;

  localparam logic [23:0] LONG_PRE_HIST = {BYTE_FF, BYTE_00, BYTE_FF};

  localparam logic [1:0] CFG_CHLOR_CMD   = 2'd0;
  localparam logic [1:0] CFG_MASTER_ADDR = 2'd1;
  localparam logic [1:0] CFG_CHLOR_ADDR  = 2'd2;

  localparam logic [7:0] CHLOR_CMD_RST   = 8'd25;
  localparam logic [7:0] MASTER_ADDR_RST = 8'd16;
  localparam logic [7:0] CHLOR_ADDR_RST  = 8'd2;

  typedef struct packed {
    logic accept;
    logic start_long;
    logic start_short;
    logic hdr_byte;
    logic len_byte;
    logic data_byte;
    logic chk_hi;
    logic short_byte;
    logic latch_long;
    logic latch_short;
    logic clear;
    logic load_hdr;
    logic load_pay;
  } ctl_cmd_t;

  typedef struct packed {
    logic long_pre;
    logic short_pre;
    logic short_term;
    logic hdr_done;
    logic len_zero;
    logic data_done;
    logic chk_second;
    logic long_fit;
    logic short_fit;
    logic short_over;
    logic out_free;
    logic em_len_zero;
    logic pay_last;
  } dp_sts_t;

  typedef struct packed {
    logic       is_header;
    logic       framing_kind;
    logic       checksum_ok;
    logic [7:0] version_byte;
    logic [7:0] target_addr;
    logic [7:0] source_addr;
    logic [7:0] command_code;
    logic [5:0] payload_length;
    logic [5:0] payload_index;
    logic [7:0] payload_byte;
    logic       last;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/dfpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dfpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/dfpd_dpath.sv]
// Datapath: byte history, header fields, checksums, payload store and output register.
`timescale 1ns / 1ps
`default_nettype none
module dfpd_dpath
  import dfpd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_byte,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata,
  input  wire ctl_cmd_t   cmd,
  output dp_sts_t         sts,
  input  wire logic       out_tready,
  output logic            out_valid,
  output out_item_t       out_item
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  logic [23:0] recent_r, recent_nxt;
  logic [7:0]  ver_r, ver_nxt, tgt_r, tgt_nxt, src_r, src_nxt, hcmd_r, hcmd_nxt;
  logic [7:0]  exp_len_r, exp_len_nxt, bc_r, bc_nxt, rx_hi_r, rx_hi_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [15:0] sum_r, sum_nxt, sum_add;
  logic [7:0]  cfg_cmd_r, cfg_master_r, cfg_chlor_r;

  logic       em_kind_r, em_ok_r;
  logic [7:0] em_ver_r, em_tgt_r, em_src_r, em_cmd_r;
  logic [5:0] em_len_r, idx_r;

  logic      out_valid_r;
  out_item_t item_r;

  logic [7:0] short_chk, short_calc;
  logic [7:0] ram_rdata;
  logic       ram_we;

  assign sum_add    = 16'(sum_r + {8'h00, in_byte});
  assign short_chk  = recent_r[15:8];
  assign short_calc = 8'(sum_r[7:0] - short_chk - BYTE_DLE);

  always_comb begin
    sts.long_pre    = (recent_r == LONG_PRE_HIST) && (in_byte == BYTE_A5);
    sts.short_pre   = (recent_r[7:0] == BYTE_DLE) && (in_byte == BYTE_STX);
    sts.short_term  = (recent_r[7:0] == BYTE_DLE) && (in_byte == BYTE_ETX);
    sts.hdr_done    = (bc_r == 8'd3);
    sts.len_zero    = (in_byte == 8'h00);
    sts.data_done   = (9'({1'b0, bc_r} + 9'd1) >= {1'b0, exp_len_r});
    sts.chk_second  = (bc_r != 8'd0);
    sts.long_fit    = ({1'b0, exp_len_r} <= 9'(PAYLOAD_DEPTH));
    sts.short_fit   = (bc_r >= 8'd2) && ({1'b0, 8'(bc_r - 8'd2)} <= 9'(PAYLOAD_DEPTH));
    sts.short_over  = ({1'b0, bc_r} > 9'(PAYLOAD_DEPTH + 1));
    sts.out_free    = !out_valid_r || out_tready;
    sts.em_len_zero = (em_len_r == 6'd0);
    sts.pay_last    = (7'({1'b0, idx_r} + 7'd1) == {1'b0, em_len_r});
  end

  always_comb begin
    recent_nxt  = recent_r;
    ver_nxt     = ver_r;
    tgt_nxt     = tgt_r;
    src_nxt     = src_r;
    hcmd_nxt    = hcmd_r;
    exp_len_nxt = exp_len_r;
    bc_nxt      = bc_r;
    rx_hi_nxt   = rx_hi_r;
    first_nxt   = first_r;
    sum_nxt     = sum_r;
    if (cmd.accept) begin
      recent_nxt = {recent_r[15:0], in_byte};
    end
    if (cmd.start_long) begin
      sum_nxt = {8'h00, BYTE_A5};
      bc_nxt  = 8'd0;
    end
    if (cmd.start_short) begin
      sum_nxt = {8'h00, SEED_SHRT};
      bc_nxt  = 8'd0;
    end
    if (cmd.hdr_byte) begin
      case (bc_r[1:0])
        2'd0:    ver_nxt  = in_byte;
        2'd1:    tgt_nxt  = in_byte;
        2'd2:    src_nxt  = in_byte;
        default: hcmd_nxt = in_byte;
      endcase
      sum_nxt = sum_add;
      bc_nxt  = sts.hdr_done ? 8'd0 : 8'(bc_r + 8'd1);
    end
    if (cmd.len_byte) begin
      exp_len_nxt = in_byte;
      sum_nxt     = sum_add;
      bc_nxt      = 8'd0;
    end
    if (cmd.data_byte) begin
      sum_nxt = sum_add;
      bc_nxt  = sts.data_done ? 8'd0 : 8'(bc_r + 8'd1);
    end
    if (cmd.chk_hi) begin
      rx_hi_nxt = in_byte;
      bc_nxt    = 8'd1;
    end
    if (cmd.short_byte) begin
      if (bc_r == 8'd0) begin
        first_nxt = in_byte;
      end
      sum_nxt = {8'h00, 8'(sum_r[7:0] + in_byte)};
      bc_nxt  = 8'(bc_r + 8'd1);
    end
    if (cmd.clear) begin
      recent_nxt  = '0;
      ver_nxt     = '0;
      tgt_nxt     = '0;
      src_nxt     = '0;
      hcmd_nxt    = '0;
      exp_len_nxt = '0;
      bc_nxt      = '0;
      rx_hi_nxt   = '0;
      sum_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r     <= '0;
      ver_r        <= '0;
      tgt_r        <= '0;
      src_r        <= '0;
      hcmd_r       <= '0;
      exp_len_r    <= '0;
      bc_r         <= '0;
      rx_hi_r      <= '0;
      first_r      <= '0;
      sum_r        <= '0;
      cfg_cmd_r    <= CHLOR_CMD_RST;
      cfg_master_r <= MASTER_ADDR_RST;
      cfg_chlor_r  <= CHLOR_ADDR_RST;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      recent_r  <= recent_nxt;
      ver_r     <= ver_nxt;
      tgt_r     <= tgt_nxt;
      src_r     <= src_nxt;
      hcmd_r    <= hcmd_nxt;
      exp_len_r <= exp_len_nxt;
      bc_r      <= bc_nxt;
      rx_hi_r   <= rx_hi_nxt;
      first_r   <= first_nxt;
      sum_r     <= sum_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CHLOR_CMD:   cfg_cmd_r    <= cfg_wdata;
          CFG_MASTER_ADDR: cfg_master_r <= cfg_wdata;
          CFG_CHLOR_ADDR:  cfg_chlor_r  <= cfg_wdata;
          default:         ;
        endcase
      end
      if (cmd.load_hdr || cmd.load_pay) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load_hdr) begin
        idx_r <= '0;
      end else if (cmd.load_pay) begin
        idx_r <= 6'(idx_r + 6'd1);
      end
    end
  end

  // Frame summary held for the emission burst
  always_ff @(posedge clk) begin
    if (cmd.latch_long) begin
      em_kind_r <= 1'b0;
      em_ok_r   <= ({rx_hi_r, in_byte} == sum_r);
      em_ver_r  <= ver_r;
      em_tgt_r  <= tgt_r;
      em_src_r  <= src_r;
      em_cmd_r  <= hcmd_r;
      em_len_r  <= exp_len_r[5:0];
    end else if (cmd.latch_short) begin
      em_kind_r <= 1'b1;
      em_ok_r   <= (short_calc == short_chk);
      em_ver_r  <= 8'h00;
      em_cmd_r  <= cfg_cmd_r;
      if (first_r == BYTE_DIR) begin
        em_src_r <= cfg_master_r;
        em_tgt_r <= cfg_chlor_r;
      end else begin
        em_src_r <= cfg_chlor_r;
        em_tgt_r <= cfg_master_r;
      end
      em_len_r <= 6'(bc_r - 8'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr || cmd.load_pay) begin
      item_r.is_header      <= cmd.load_hdr;
      item_r.framing_kind   <= em_kind_r;
      item_r.checksum_ok    <= em_ok_r;
      item_r.version_byte   <= em_ver_r;
      item_r.target_addr    <= em_tgt_r;
      item_r.source_addr    <= em_src_r;
      item_r.command_code   <= em_cmd_r;
      item_r.payload_length <= em_len_r;
      item_r.payload_index  <= cmd.load_hdr ? 6'd0 : idx_r;
      item_r.payload_byte   <= cmd.load_hdr ? 8'h00 : ram_rdata;
      item_r.last           <= cmd.load_hdr ? sts.em_len_zero : sts.pay_last;
    end
  end

  assign ram_we = (cmd.data_byte || cmd.short_byte) && ({1'b0, bc_r} < 9'(PAYLOAD_DEPTH));

  dfpd_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bc_r[AW-1:0]),
    .wdata (in_byte),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

[rtl/dfpd_ctrl.sv]
// Controller: frame parse phases and the result emission sequence.
`timescale 1ns / 1ps
`default_nettype none
module dfpd_ctrl
  import dfpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire dp_sts_t sts,
  output ctl_cmd_t     cmd
);

  typedef enum logic [8:0] {
    ST_HUNT  = 9'b000000001,
    ST_HDR   = 9'b000000010,
    ST_LEN   = 9'b000000100,
    ST_DATA  = 9'b000001000,
    ST_CHK   = 9'b000010000,
    ST_SHORT = 9'b000100000,
    ST_HEAD  = 9'b001000000,
    ST_FETCH = 9'b010000000,
    ST_PAY   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_tready = (state_r == ST_HUNT) || (state_r == ST_HDR) || (state_r == ST_LEN) ||
                     (state_r == ST_DATA) || (state_r == ST_CHK) || (state_r == ST_SHORT);
  assign acc = in_tvalid && in_tready;

  always_comb begin
    cmd        = '0;
    cmd.accept = acc;
    state_nxt  = state_r;
    case (state_r)
      ST_HUNT: begin
        if (acc) begin
          if (sts.long_pre) begin
            cmd.start_long = 1'b1;
            state_nxt      = ST_HDR;
          end else if (sts.short_pre) begin
            cmd.start_short = 1'b1;
            state_nxt       = ST_SHORT;
          end
        end
      end
      ST_HDR: begin
        if (acc) begin
          cmd.hdr_byte = 1'b1;
          if (sts.hdr_done) begin
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (acc) begin
          cmd.len_byte = 1'b1;
          state_nxt    = sts.len_zero ? ST_CHK : ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd.data_byte = 1'b1;
          if (sts.data_done) begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (acc) begin
          if (!sts.chk_second) begin
            cmd.chk_hi = 1'b1;
          end else begin
            cmd.clear      = 1'b1;
            cmd.latch_long = sts.long_fit;
            state_nxt      = sts.long_fit ? ST_HEAD : ST_HUNT;
          end
        end
      end
      ST_SHORT: begin
        if (acc) begin
          if (sts.short_term) begin
            cmd.clear       = 1'b1;
            cmd.latch_short = sts.short_fit;
            state_nxt       = sts.short_fit ? ST_HEAD : ST_HUNT;
          end else if (sts.short_over) begin
            cmd.clear = 1'b1;
            state_nxt = ST_HUNT;
          end else begin
            cmd.short_byte = 1'b1;
          end
        end
      end
      ST_HEAD: begin
        if (sts.out_free) begin
          cmd.load_hdr = 1'b1;
          state_nxt    = sts.em_len_zero ? ST_HUNT : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_PAY;
      end
      ST_PAY: begin
        if (sts.out_free) begin
          cmd.load_pay = 1'b1;
          state_nxt    = sts.pay_last ? ST_HUNT : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/dual_framing_packet_deframer_unit.sv]
// Top level of the dual-framing packet deframer.
`timescale 1ns / 1ps
`default_nettype none
// Takes one received bus byte per input transaction and recognises long frames
// (FF 00 FF A5 preamble, header, length, payload, 16-bit big-endian sum) and short
// frames (10 02, payload, 8-bit sum, 10 03). While parsing, a byte is taken every
// cycle. When a frame completes, input is held off while the block emits a header
// transaction and then one transaction per payload byte, the last with tlast set.
// Before each payload byte a fetch state covers the registered read of the payload
// RAM; header and payload loads also wait for a free output register. Frames whose
// payload does not fit PAYLOAD_DEPTH are dropped silently. No clearing pass is
// needed after reset.
module dual_framing_packet_deframer_unit
  import dfpd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // checksum_ok, version_byte, target_addr, source_addr, command_code,
  // payload_length, payload_index, payload_byte, zero pad
  output logic [55:0]      out_tdata,
  output logic [1:0]       out_tuser,  // is_header, framing_kind
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  ctl_cmd_t  cmd;
  dp_sts_t   sts;
  out_item_t out_item;

  dfpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dfpd_dpath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_item   (out_item)
  );

  assign out_tdata = {3'b000, out_item.payload_byte, out_item.payload_index,
                      out_item.payload_length, out_item.command_code,
                      out_item.source_addr, out_item.target_addr,
                      out_item.version_byte, out_item.checksum_ok};
  assign out_tuser = {out_item.framing_kind, out_item.is_header};
  assign out_tlast = out_item.last;

`ifndef SYNTHESIS
  a_pay_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_item.is_header) |->
      (out_item.payload_index < out_item.payload_length))
    else $error("payload index beyond frame length");

  a_pay_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_item.is_header) |->
      (out_item.last == (7'({1'b0, out_item.payload_index} + 7'd1) ==
                         {1'b0, out_item.payload_length})))
    else $error("payload last mark misplaced");

  a_hdr_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_item.is_header) |->
      ((out_item.last == (out_item.payload_length == 6'd0)) &&
       (out_item.payload_index == 6'd0)))
    else $error("header last mark or index wrong");

  a_no_double_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_item.is_header && !out_item.last) |=>
      !(out_tvalid && out_item.is_header))
    else $error("header followed by header inside a frame");
`endif

endmodule
`default_nettype wire
